FILE: rtl/mfs_pkg.sv
package mfs_pkg;

   // Default length of the leading region scanned for the 3MF part name
   localparam int unsigned SEARCH_WINDOW_DEF = 4096;

   // Size thresholds, in bytes
   localparam int unsigned MIN_SIZE      = 20;
   localparam int unsigned FBXB_MIN_SIZE = 23;
   localparam int unsigned IGES_MIN_SIZE = 80;
   localparam int unsigned IGES_FLAG_POS = 72;

   // Header prefixes
   localparam int unsigned PREFIX_NUM = 7;
   localparam int unsigned PREFIX_MAX = 18;
   localparam int unsigned PIDX_W     = $clog2(PREFIX_MAX);

   localparam int unsigned PFX_FBXB  = 0;  // FBX binary signature text
   localparam int unsigned PFX_FBXA  = 1;  // "; FBX"
   localparam int unsigned PFX_USDC  = 2;  // "PXR-USDC"
   localparam int unsigned PFX_ZIPLH = 3;  // "PK" 03 04, zip local header
   localparam int unsigned PFX_USDA  = 4;  // "#usda"
   localparam int unsigned PFX_ZIP   = 5;  // "PK"
   localparam int unsigned PFX_STEP  = 6;  // "ISO-10303-21"

   localparam int unsigned PREFIX_LEN [PREFIX_NUM] = '{18, 5, 8, 4, 5, 2, 12};

   localparam logic [7:0] PREFIX_TEXT [PREFIX_NUM][PREFIX_MAX] = '{
      '{8'h4B, 8'h61, 8'h79, 8'h64, 8'h61, 8'h72, 8'h61, 8'h20, 8'h46,
        8'h42, 8'h58, 8'h20, 8'h42, 8'h69, 8'h6E, 8'h61, 8'h72, 8'h79},
      '{8'h3B, 8'h20, 8'h46, 8'h42, 8'h58, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h58, 8'h52, 8'h2D, 8'h55, 8'h53, 8'h44, 8'h43, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h23, 8'h75, 8'h73, 8'h64, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h49, 8'h53, 8'h4F, 8'h2D, 8'h31, 8'h30, 8'h33, 8'h30, 8'h33,
        8'h2D, 8'h32, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // 3MF part name "3dmodel.model"; the history holds all but its last byte
   localparam int unsigned NAME_LEN = 13;
   localparam int unsigned HIST_LEN = NAME_LEN - 1;
   localparam logic [7:0] NAME_TEXT [NAME_LEN] = '{
      8'h33, 8'h64, 8'h6D, 8'h6F, 8'h64, 8'h65, 8'h6C,
      8'h2E, 8'h6D, 8'h6F, 8'h64, 8'h65, 8'h6C
   };

   // IGES section letters at the flag offset
   localparam logic [7:0] IGES_S = 8'h53;
   localparam logic [7:0] IGES_G = 8'h47;
   localparam logic [7:0] IGES_D = 8'h44;

   typedef enum logic [3:0] {
      FMT_UNKNOWN  = 4'd0,
      FMT_FBX_BIN  = 4'd1,
      FMT_FBX_ASC  = 4'd2,
      FMT_USD_CRT  = 4'd3,
      FMT_USDZ     = 4'd4,
      FMT_USD_ASC  = 4'd5,
      FMT_3MF      = 4'd6,
      FMT_STEP     = 4'd7,
      FMT_IGES     = 4'd8
   } format_type;

endpackage

FILE: rtl/mfs_if.sv
interface mfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] format_code;

   modport source (output valid, output format_code, input ready);
   modport sink (input valid, input format_code, output ready);
endinterface

FILE: rtl/model_format_sniffer_core.sv
// Model file format sniffer. Stream a file in as one byte per item, offset zero
// first, and mark the final byte with last_byte; one item with the format code
// comes out in the cycle after that final byte, and the detector is then clear for
// the next file. A byte is taken every cycle: the only stall is when the result
// register still holds an unread code and the sink is not taking it this cycle.
// Detection covers the fixed header prefixes (FBX binary and ASCII, USD crate
// and ASCII, zip heads, STEP), the 3MF part name inside the first SEARCH_WINDOW
// bytes (a name ending on the window's last byte counts), and the IGES section
// letter at offset 72. Files shorter than 20 bytes always report unknown; only
// the last byte of a file produces a result.
module model_format_sniffer_core #(
   parameter int unsigned SEARCH_WINDOW = mfs_pkg::SEARCH_WINDOW_DEF
) (
   input logic        clock,
   input logic        reset,
   mfs_req_if.sink    req,
   mfs_rsp_if.source  rsp
);

   // Position saturates past both the window and the IGES size test
   localparam int unsigned POS_CAP = (SEARCH_WINDOW > mfs_pkg::IGES_MIN_SIZE) ?
                                     SEARCH_WINDOW : mfs_pkg::IGES_MIN_SIZE;
   localparam int unsigned POS_W   = $clog2(POS_CAP + 1);

   logic [POS_W-1:0]                pos_ff, pos_in;
   logic [mfs_pkg::PREFIX_NUM-1:0]  alive_ff, alive_in, alive_next;
   logic [7:0]                      recent_ff [mfs_pkg::HIST_LEN];
   logic                            name_found_ff, name_found_in, name_next;
   logic                            iges_ff, iges_in, iges_next;
   logic                            name_hit;
   logic                            rsp_valid_ff, rsp_valid_in;
   mfs_pkg::format_type             code_ff, code_in;
   logic                            accept;
   logic                            last_accept;

   assign req.ready   = !rsp_valid_ff || rsp.ready;
   assign accept      = req.valid && req.ready;
   assign last_accept = accept && req.last_byte;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.format_code = code_ff;

   // Per-byte compares: prefixes, name close, IGES flag
   always_comb begin
      alive_next = alive_ff;
      for (int k = 0; k < mfs_pkg::PREFIX_NUM; k++) begin
         if (pos_ff < POS_W'(mfs_pkg::PREFIX_LEN[k]) &&
             req.data_byte != mfs_pkg::PREFIX_TEXT[k][pos_ff[mfs_pkg::PIDX_W-1:0]]) begin
            alive_next[k] = 1'b0;
         end
      end

      // The current byte closes a match when the twelve before it spell the rest
      name_hit = (pos_ff >= POS_W'(mfs_pkg::HIST_LEN)) &&
                 (pos_ff < POS_W'(SEARCH_WINDOW)) &&
                 (req.data_byte == mfs_pkg::NAME_TEXT[mfs_pkg::NAME_LEN-1]);
      for (int k = 0; k < mfs_pkg::HIST_LEN; k++) begin
         if (recent_ff[k] != mfs_pkg::NAME_TEXT[k]) begin
            name_hit = 1'b0;
         end
      end
      name_next = name_found_ff || name_hit;

      iges_next = iges_ff ||
                  ((pos_ff == POS_W'(mfs_pkg::IGES_FLAG_POS)) &&
                   (req.data_byte inside {mfs_pkg::IGES_S, mfs_pkg::IGES_G,
                                          mfs_pkg::IGES_D}));
   end

   // Decision on the final byte; size is pos_ff + 1, so thresholds drop by one
   always_comb begin
      if (pos_ff < POS_W'(mfs_pkg::MIN_SIZE - 1)) begin
         code_in = mfs_pkg::FMT_UNKNOWN;
      end else if (alive_next[mfs_pkg::PFX_FBXB] &&
                   pos_ff >= POS_W'(mfs_pkg::FBXB_MIN_SIZE - 1)) begin
         code_in = mfs_pkg::FMT_FBX_BIN;
      end else if (alive_next[mfs_pkg::PFX_FBXA]) begin
         code_in = mfs_pkg::FMT_FBX_ASC;
      end else if (alive_next[mfs_pkg::PFX_USDC]) begin
         code_in = mfs_pkg::FMT_USD_CRT;
      end else if (alive_next[mfs_pkg::PFX_ZIP] && name_next) begin
         code_in = mfs_pkg::FMT_3MF;
      end else if (alive_next[mfs_pkg::PFX_ZIPLH]) begin
         code_in = mfs_pkg::FMT_USDZ;
      end else if (alive_next[mfs_pkg::PFX_USDA]) begin
         code_in = mfs_pkg::FMT_USD_ASC;
      end else if (alive_next[mfs_pkg::PFX_STEP]) begin
         code_in = mfs_pkg::FMT_STEP;
      end else if (pos_ff >= POS_W'(mfs_pkg::IGES_MIN_SIZE - 1) && iges_next) begin
         code_in = mfs_pkg::FMT_IGES;
      end else begin
         code_in = mfs_pkg::FMT_UNKNOWN;
      end
   end

   // Next state: advance on each byte, clear at the end of a file
   always_comb begin
      pos_in        = pos_ff;
      alive_in      = alive_ff;
      name_found_in = name_found_ff;
      iges_in       = iges_ff;
      if (accept) begin
         if (req.last_byte) begin
            pos_in        = '0;
            alive_in      = '1;
            name_found_in = 1'b0;
            iges_in       = 1'b0;
         end else begin
            pos_in        = (pos_ff < POS_W'(POS_CAP)) ? pos_ff + POS_W'(1) : pos_ff;
            alive_in      = alive_next;
            name_found_in = name_next;
            iges_in       = iges_next;
         end
      end

      // Hold the result until the sink takes it
      rsp_valid_in = rsp_valid_ff;
      if (last_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         alive_ff      <= '1;
         name_found_ff <= 1'b0;
         iges_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         alive_ff      <= alive_in;
         name_found_ff <= name_found_in;
         iges_ff       <= iges_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // History needs no clear: a name match is only tested once twelve bytes
   // of the current file have shifted in
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < mfs_pkg::HIST_LEN - 1; k++) begin
            recent_ff[k] <= recent_ff[k+1];
         end
         recent_ff[mfs_pkg::HIST_LEN-1] <= req.data_byte;
      end
      if (last_accept) begin
         code_ff <= code_in;
      end
   end

   // A result appears only after a final byte was taken
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last_accept))
      else $error("result raised without a final byte");

   // State is back to its idle values after each file
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      last_accept |=> (pos_ff == '0) && (alive_ff == '1) && !name_found_ff && !iges_ff)
      else $error("state not cleared after final byte");

   // Short files always classify as unknown
   a_short_unknown: assert property (@(posedge clock) disable iff (reset)
      (last_accept && pos_ff < POS_W'(mfs_pkg::MIN_SIZE - 1)) |=>
      (rsp_valid_ff && code_ff == mfs_pkg::FMT_UNKNOWN))
      else $error("short file not reported unknown");

   // Position saturates at its cap
   a_pos_cap: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(POS_CAP))
      else $error("byte position beyond cap");

endmodule

FILE: bench/tb_model_format_sniffer_core.sv
module tb_model_format_sniffer_core;
   timeunit 1ns;
   timeprecision 1ps;

   // Name search window of the instance; the byte counter saturates at the
   // larger of the window and the IGES size threshold.
   localparam int unsigned WINDOW       = mfs_pkg::SEARCH_WINDOW_DEF;
   localparam int unsigned POS_SAT      = (WINDOW > mfs_pkg::IGES_MIN_SIZE) ?
                                          WINDOW : mfs_pkg::IGES_MIN_SIZE;
   localparam int unsigned RAND_BYTES   = 1150;
   localparam int unsigned RAND_FILES   = 40;
   localparam int unsigned IDLE_MAX     = 16;
   localparam int unsigned EDGE_IDLE    = 3;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam longint unsigned CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;

   mfs_req_if req ();
   mfs_rsp_if rsp ();

   model_format_sniffer_core #(
      .SEARCH_WINDOW(WINDOW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   // Sniffer state as the block should hold it between bytes of one file
   int unsigned     sniff_pos;
   logic [mfs_pkg::PREFIX_NUM-1:0] live_prefixes;
   logic [7:0]      tail_bytes [mfs_pkg::HIST_LEN];
   bit              name_seen;
   bit              iges_flag;

   // Format codes still owed by the block, oldest first
   mfs_pkg::format_type pending_formats [$];
   mfs_pkg::format_type want_format;

   // File under construction and run bookkeeping
   logic [7:0]      file_bytes [$];
   int unsigned     gap_max;
   int unsigned     stall_max;
   int unsigned     next_gap;
   int unsigned     stall_left;
   bit              req_held;
   int unsigned     bytes_sent;
   int unsigned     files_sent;
   int unsigned     codes_checked = 0;
   int unsigned     mismatches = 0;
   int unsigned     format_hits [mfs_pkg::FMT_IGES+1] = '{default: 0};
   longint unsigned cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles, %0d format codes still pending",
                  $time, cycles, pending_formats.size());
         $display("FAIL model_format_sniffer_core");
         $finish;
      end
   end

   // Return the predicted state to what it is after reset or after a last byte
   function automatic void clear_sniffer();
      sniff_pos     = 0;
      live_prefixes = '1;
      for (int k = 0; k < mfs_pkg::HIST_LEN; k++) tail_bytes[k] = 8'h00;
      name_seen     = 1'b0;
      iges_flag     = 1'b0;
   endfunction

   // Advance the predicted state by one accepted byte; at the last byte of a
   // file, decide the format and queue it as the next code owed.
   function automatic void classify_byte(input logic [7:0] b, input logic lst);
      int unsigned p;
      int unsigned size;
      bit          hit;
      mfs_pkg::format_type code;
      p = sniff_pos;
      // drop every prefix that this byte contradicts
      for (int k = 0; k < mfs_pkg::PREFIX_NUM; k++)
         if (p < mfs_pkg::PREFIX_LEN[k] && b != mfs_pkg::PREFIX_TEXT[k][p])
            live_prefixes[k] = 1'b0;
      // this byte may close the part name; the whole name must lie in the window
      if (p >= mfs_pkg::HIST_LEN && p < WINDOW &&
          b == mfs_pkg::NAME_TEXT[mfs_pkg::NAME_LEN-1]) begin
         hit = 1'b1;
         for (int k = 0; k < mfs_pkg::HIST_LEN; k++)
            if (tail_bytes[k] != mfs_pkg::NAME_TEXT[k]) hit = 1'b0;
         if (hit) name_seen = 1'b1;
      end
      if (p == mfs_pkg::IGES_FLAG_POS &&
          (b == mfs_pkg::IGES_S || b == mfs_pkg::IGES_G || b == mfs_pkg::IGES_D))
         iges_flag = 1'b1;
      for (int k = 0; k < mfs_pkg::HIST_LEN - 1; k++) tail_bytes[k] = tail_bytes[k+1];
      tail_bytes[mfs_pkg::HIST_LEN-1] = b;
      if (sniff_pos < POS_SAT) sniff_pos++;
      if (lst) begin
         size = p + 1;
         // priority order matters: the 3MF test sits ahead of the USDZ test
         if (size < mfs_pkg::MIN_SIZE)
            code = mfs_pkg::FMT_UNKNOWN;
         else if (live_prefixes[mfs_pkg::PFX_FBXB] && size >= mfs_pkg::FBXB_MIN_SIZE)
            code = mfs_pkg::FMT_FBX_BIN;
         else if (live_prefixes[mfs_pkg::PFX_FBXA])
            code = mfs_pkg::FMT_FBX_ASC;
         else if (live_prefixes[mfs_pkg::PFX_USDC])
            code = mfs_pkg::FMT_USD_CRT;
         else if (live_prefixes[mfs_pkg::PFX_ZIP] && name_seen)
            code = mfs_pkg::FMT_3MF;
         else if (live_prefixes[mfs_pkg::PFX_ZIPLH])
            code = mfs_pkg::FMT_USDZ;
         else if (live_prefixes[mfs_pkg::PFX_USDA])
            code = mfs_pkg::FMT_USD_ASC;
         else if (live_prefixes[mfs_pkg::PFX_STEP])
            code = mfs_pkg::FMT_STEP;
         else if (size >= mfs_pkg::IGES_MIN_SIZE && iges_flag)
            code = mfs_pkg::FMT_IGES;
         else
            code = mfs_pkg::FMT_UNKNOWN;
         pending_formats.push_back(code);
         clear_sniffer();
      end
   endfunction

   // Result side: check every accepted code against the oldest one owed, then
   // draw how long to hold ready low before taking the next code.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left = 0;
      end else if (rsp.valid && rsp.ready) begin
         codes_checked++;
         if (rsp.format_code <= mfs_pkg::FMT_IGES) format_hits[rsp.format_code]++;
         if (pending_formats.size() == 0) begin
            mismatches++;
            $display("%0t ns: format_code expected none, got %0d", $time, rsp.format_code);
         end else begin
            want_format = pending_formats.pop_front();
            if (rsp.format_code !== want_format) begin
               mismatches++;
               $display("%0t ns: format_code expected %0d (%s), got %0d", $time,
                        want_format, want_format.name(), rsp.format_code);
            end
         end
         stall_left = $urandom_range(0, stall_max);
         rsp.ready <= (stall_left == 0);
      end else if (!rsp.ready) begin
         if (stall_left != 0) stall_left--;
         if (stall_left == 0) rsp.ready <= 1'b1;
      end
   end

   function automatic void set_idling(input int unsigned max_wait);
      gap_max   = max_wait;
      stall_max = max_wait;
   endfunction

   // Start a new file of len bytes, random or filled with one value
   function automatic void start_file(input int unsigned len, input bit noisy,
                                      input logic [7:0] fill);
      file_bytes.delete();
      for (int unsigned i = 0; i < len; i++)
         file_bytes.push_back(noisy ? 8'($urandom) : fill);
   endfunction

   // Write a header prefix at offset zero, clipped to the file
   function automatic void put_prefix(input int unsigned pfx);
      for (int unsigned i = 0; i < mfs_pkg::PREFIX_LEN[pfx] && i < file_bytes.size(); i++)
         file_bytes[i] = mfs_pkg::PREFIX_TEXT[pfx][i];
   endfunction

   // Write the 3MF part name starting at off, clipped to the file
   function automatic void put_name(input int unsigned off);
      for (int unsigned i = 0; i < mfs_pkg::NAME_LEN && off + i < file_bytes.size(); i++)
         file_bytes[off+i] = mfs_pkg::NAME_TEXT[i];
   endfunction

   // Offer one byte and hold it until accepted. The gap before the next byte
   // is drawn at acceptance, so valid is dropped only when a gap follows and
   // never lowered and raised again within one step.
   task automatic send_byte(input logic [7:0] b, input logic lst);
      repeat (next_gap) @(posedge clock);
      req.valid     <= 1'b1;
      req.data_byte <= b;
      req.last_byte <= lst;
      req_held = 1'b1;
      do @(posedge clock); while (!req.ready);
      classify_byte(b, lst);
      bytes_sent++;
      next_gap = $urandom_range(0, gap_max);
      if (next_gap != 0) begin
         req.valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic send_file();
      for (int unsigned i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
   endtask

   // Size threshold, byte extremes and back-to-back one-byte files
   task automatic test_short_files();
      start_file(1, 1'b0, 8'h00);
      send_file();
      start_file(1, 1'b0, 8'hFF);
      send_file();
      set_idling(0);
      start_file(1, 1'b0, 8'h5A);
      send_file();
      start_file(2, 1'b1, 8'h00);
      send_file();
      set_idling(IDLE_MAX);
      start_file(30, 1'b0, 8'h00);
      send_file();
      start_file(30, 1'b0, 8'hFF);
      send_file();
      // one byte below and exactly at the minimum size
      start_file(mfs_pkg::MIN_SIZE - 1, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_FBXA);
      send_file();
      start_file(mfs_pkg::MIN_SIZE, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_FBXA);
      send_file();
   endtask

   // Every header prefix, the FBX binary size threshold, a prefix broken on its
   // final byte, and FBX ASCII winning over an IGES flag
   task automatic test_prefixes();
      start_file(mfs_pkg::FBXB_MIN_SIZE - 1, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_FBXB);
      send_file();
      start_file(mfs_pkg::FBXB_MIN_SIZE, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_FBXB);
      send_file();
      foreach (mfs_pkg::PREFIX_LEN[k]) begin
         start_file(24, 1'b1, 8'h00);
         put_prefix(k);
         send_file();
      end
      start_file(24, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_STEP);
      file_bytes[mfs_pkg::PREFIX_LEN[mfs_pkg::PFX_STEP]-1] =
         ~mfs_pkg::PREFIX_TEXT[mfs_pkg::PFX_STEP][mfs_pkg::PREFIX_LEN[mfs_pkg::PFX_STEP]-1];
      send_file();
      start_file(mfs_pkg::IGES_MIN_SIZE, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_FBXA);
      file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_S;
      send_file();
   endtask

   // Zip heads with and without the part name, and the name with no zip head
   task automatic test_zip_names();
      // the earliest place the name can sit behind "PK"
      start_file(mfs_pkg::MIN_SIZE, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_ZIP);
      put_name(mfs_pkg::PREFIX_LEN[mfs_pkg::PFX_ZIP]);
      send_file();
      start_file(40, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_ZIPLH);
      put_name(20);
      send_file();
      start_file(40, 1'b1, 8'h00);
      put_name(0);
      send_file();
      // name one byte short of a match
      start_file(40, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_ZIPLH);
      put_name(10);
      file_bytes[10 + mfs_pkg::NAME_LEN - 1] = 8'h00;
      send_file();
   endtask

   // IGES flag letters and the size threshold around it
   task automatic test_iges_flag();
      start_file(mfs_pkg::IGES_MIN_SIZE, 1'b1, 8'h00);
      file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_S;
      send_file();
      start_file(mfs_pkg::IGES_MIN_SIZE - 1, 1'b1, 8'h00);
      file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_G;
      send_file();
      start_file(mfs_pkg::IGES_MIN_SIZE + 1, 1'b1, 8'h00);
      file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_D;
      send_file();
      start_file(mfs_pkg::IGES_MIN_SIZE, 1'b1, 8'h00);
      file_bytes[mfs_pkg::IGES_FLAG_POS] = 8'h54;
      send_file();
   endtask

   // Name ending on the last byte inside the window and one byte past it, and
   // a file long enough to saturate the byte counter
   task automatic test_window_edge();
      set_idling(EDGE_IDLE);
      start_file(WINDOW + 2, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_ZIPLH);
      put_name(WINDOW - mfs_pkg::NAME_LEN);
      send_file();
      start_file(WINDOW + 2, 1'b1, 8'h00);
      put_prefix(mfs_pkg::PFX_ZIPLH);
      put_name(WINDOW - mfs_pkg::NAME_LEN + 1);
      send_file();
      start_file(WINDOW + 300, 1'b1, 8'h00);
      file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_S;
      send_file();
      set_idling(IDLE_MAX);
   endtask

   // Random files: mostly well-formed headers with random bodies, the rest noise,
   // IGES flag files and headers broken on one byte
   task automatic test_random_files();
      int unsigned first_byte;
      int unsigned rand_files;
      int unsigned pfx;
      int unsigned off;
      first_byte = bytes_sent;
      rand_files = 0;
      while (bytes_sent - first_byte < RAND_BYTES || rand_files < RAND_FILES) begin
         // one file in five runs with no idling on either side
         set_idling(($urandom_range(0, 4) == 0) ? 0 : IDLE_MAX);
         case ($urandom_range(0, 9))
            0: start_file($urandom_range(1, 60), 1'b1, 8'h00);
            1, 2, 3, 4: begin
               start_file($urandom_range(15, 45), 1'b1, 8'h00);
               put_prefix($urandom_range(0, mfs_pkg::PREFIX_NUM - 1));
            end
            5, 6: begin
               pfx = ($urandom_range(0, 1) == 0) ? mfs_pkg::PFX_ZIP : mfs_pkg::PFX_ZIPLH;
               start_file($urandom_range(mfs_pkg::MIN_SIZE, 60), 1'b1, 8'h00);
               put_prefix(pfx);
               off = $urandom_range(mfs_pkg::PREFIX_LEN[pfx],
                                    file_bytes.size() - mfs_pkg::NAME_LEN);
               put_name(off);
               // spoil the name now and then
               if ($urandom_range(0, 3) == 0)
                  file_bytes[off + $urandom_range(0, mfs_pkg::NAME_LEN - 1)] ^=
                     8'($urandom_range(1, 255));
            end
            7, 8: begin
               start_file($urandom_range(70, 100), 1'b1, 8'h00);
               if (file_bytes.size() > mfs_pkg::IGES_FLAG_POS) begin
                  case ($urandom_range(0, 3))
                     0: file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_S;
                     1: file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_G;
                     2: file_bytes[mfs_pkg::IGES_FLAG_POS] = mfs_pkg::IGES_D;
                     default: file_bytes[mfs_pkg::IGES_FLAG_POS] = 8'($urandom);
                  endcase
               end
            end
            default: begin
               pfx = $urandom_range(0, mfs_pkg::PREFIX_NUM - 1);
               start_file($urandom_range(15, 45), 1'b1, 8'h00);
               put_prefix(pfx);
               file_bytes[$urandom_range(0, mfs_pkg::PREFIX_LEN[pfx] - 1)] ^=
                  8'($urandom_range(1, 255));
            end
         endcase
         // mix in a stray part name to exercise the priority order
         if ($urandom_range(0, 5) == 0 && file_bytes.size() >= mfs_pkg::NAME_LEN)
            put_name($urandom_range(0, file_bytes.size() - mfs_pkg::NAME_LEN));
         send_file();
         rand_files++;
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.data_byte <= 8'h00;
      req.last_byte <= 1'b0;
      bytes_sent    = 0;
      files_sent    = 0;
      next_gap      = 0;
      req_held      = 1'b0;
      set_idling(IDLE_MAX);
      clear_sniffer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_short_files();
      test_prefixes();
      test_zip_names();
      test_iges_flag();
      test_window_edge();
      test_random_files();

      // release the request side, then drain the remaining codes
      if (req_held) req.valid <= 1'b0;
      while (pending_formats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d files (%0d bytes); checked %0d format codes, %0d mismatches",
               files_sent, bytes_sent, codes_checked, mismatches);
      $display({"Codes seen: unk %0d fbxb %0d fbxa %0d usdc %0d usdz %0d",
                " usda %0d 3mf %0d step %0d iges %0d"},
               format_hits[mfs_pkg::FMT_UNKNOWN], format_hits[mfs_pkg::FMT_FBX_BIN],
               format_hits[mfs_pkg::FMT_FBX_ASC], format_hits[mfs_pkg::FMT_USD_CRT],
               format_hits[mfs_pkg::FMT_USDZ], format_hits[mfs_pkg::FMT_USD_ASC],
               format_hits[mfs_pkg::FMT_3MF], format_hits[mfs_pkg::FMT_STEP],
               format_hits[mfs_pkg::FMT_IGES]);
      if (mismatches == 0) begin
         $display("PASS model_format_sniffer_core");
      end else begin
         $display("FAIL model_format_sniffer_core");
      end
      $finish;
   end

endmodule
